// File: hw/rtl/sh24_pkg.sv
package sh24_pkg;

   // initialisation constants of the four lanes
   localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

   // finalisation xor into lane c and bit offset of the length byte
   localparam logic [63:0] FINAL_XOR  = 64'h00000000000000ff;
   localparam int          LEN_SHIFT  = 56;

   // configuration register indexes
   localparam int          CSR_IDX_W    = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd1;

   // index of the last round in each phase, counted from zero
   localparam logic [1:0]  FIN_LAST_ROUND = 2'd3;
   localparam logic [1:0]  MSG_LAST_ROUND = 2'd1;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
   } lanes_type;

   // result of merging one chunk into the pending word
   typedef struct packed {
      logic        full;
      logic [63:0] full_word;
      logic [63:0] rem_word;
      logic [2:0]  rem_cnt;
      logic [3:0]  byte_cnt;
   } pack_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MSG,
      ST_FIN
   } state_type;

   // lanes at the start of a message
   function automatic lanes_type init_lanes(input logic [63:0] k0, input logic [63:0] k1);
      lanes_type l;
      l.a = SIP_C0 ^ k0;
      l.b = SIP_C1 ^ k1;
      l.c = SIP_C2 ^ k0;
      l.d = SIP_C3 ^ k1;
      return l;
   endfunction

endpackage

// File: hw/rtl/sh24_round.sv
module sh24_round (
   input  sh24_pkg::lanes_type lanes_i,
   output sh24_pkg::lanes_type lanes_o
);

   logic [63:0] a1, a2, a3, b1, b2, c1, c2, d1, d2;

   // one sipround: add, rotate, xor on both lane pairs
   always_comb begin
      a1 = lanes_i.a + lanes_i.b;
      b1 = {lanes_i.b[50:0], lanes_i.b[63:51]} ^ a1;
      a2 = {a1[31:0], a1[63:32]};
      c1 = lanes_i.c + lanes_i.d;
      d1 = {lanes_i.d[47:0], lanes_i.d[63:48]} ^ c1;
      a3 = a2 + d1;
      d2 = {d1[42:0], d1[63:43]} ^ a3;
      c2 = c1 + b1;
      b2 = {b1[46:0], b1[63:47]} ^ c2;
      lanes_o.a = a3;
      lanes_o.b = b2;
      lanes_o.c = {c2[31:0], c2[63:32]};
      lanes_o.d = d2;
   end

endmodule

// File: hw/rtl/sh24_pack.sv
module sh24_pack (
   input  logic [63:0]        pend_word_i,
   input  logic [2:0]         pend_cnt_i,
   input  logic [63:0]        data_i,
   input  logic [3:0]         count_i,
   output sh24_pkg::pack_type pack_o
);

   logic [3:0]   cnt_sat;
   logic [63:0]  masked;
   logic [127:0] combined;
   logic [3:0]   sum;

   // saturate the count and drop bytes above it
   always_comb begin
      cnt_sat = (count_i > 4'd8) ? 4'd8 : count_i;
      for (int i = 0; i < 8; i++) begin
         masked[i*8 +: 8] = (4'(i) < cnt_sat) ? data_i[i*8 +: 8] : 8'h00;
      end
   end

   // append the chunk above the pending bytes
   always_comb begin
      combined = {64'b0, pend_word_i} | ({64'b0, masked} << {pend_cnt_i, 3'b000});
      sum      = {1'b0, pend_cnt_i} + cnt_sat;
      pack_o.full      = sum[3];
      pack_o.full_word = combined[63:0];
      pack_o.rem_word  = sum[3] ? combined[127:64] : combined[63:0];
      pack_o.rem_cnt   = sum[2:0];
      pack_o.byte_cnt  = cnt_sat;
   end

endmodule

// File: hw/rtl/siphash24_stream_hasher_unit.sv
// channel   direction  handshake                 payload
// req       in         req_tvalid / req_tready   chunk_data, byte_count, last (tlast)
// rsp       out        rsp_tvalid / rsp_tready   hash
// csr       in         csr_valid / csr_ready     csr_index, csr_data
//
// one sipround unit is shared; every unstalled cycle of work runs one round.
// a chunk that does not end a message is only merged into the pending word;
// one that completes a full word runs its message rounds, the first on accept.
// a last chunk runs message rounds on a full word it completes, then on the
// padded word, then finalisation rounds, the tag registered in the final round.
// req_tready is low in ST_MSG/ST_FIN; a waiting tag only stalls the last round.
// csr writes are taken only while idle with no req word offered.
// synchronous reset clears the keys, restarts the message and drops rsp_tvalid.
module siphash24_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   // [63:0] chunk_data, [67:64] byte_count, [71:68] zero
   input  logic [71:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [63:0] hash
   output logic [63:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [sh24_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0] csr_data
);

   sh24_pkg::state_type state_ff, state_in;
   sh24_pkg::lanes_type lanes_ff, lanes_in, round_in, round_out;
   sh24_pkg::pack_type  pk;

   logic [63:0] key_low_ff, key_low_in, key_high_ff, key_high_in;
   logic [63:0] pend_word_ff, pend_word_in;
   logic [2:0]  pend_cnt_ff, pend_cnt_in;
   logic [7:0]  len_ff, len_in;
   logic [63:0] word_ff, word_in;
   logic        need_final_ff, need_final_in;
   logic        cur_final_ff, cur_final_in;
   logic [1:0]  rnd_cnt_ff, rnd_cnt_in;
   logic [63:0] hash_ff, hash_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [7:0]  len_new;
   logic [63:0] final_acc;
   logic [63:0] final_pend;
   logic [63:0] entry_xor;
   logic        slot_free;

   // chunk merge
   sh24_pack u_pack (
      .pend_word_i (pend_word_ff),
      .pend_cnt_i  (pend_cnt_ff),
      .data_i      (req_tdata[63:0]),
      .count_i     (req_tdata[67:64]),
      .pack_o      (pk)
   );

   // shared round unit
   sh24_round u_round (
      .lanes_i (round_in),
      .lanes_o (round_out)
   );

   // final words: from the chunk being accepted, or from stored state
   assign len_new    = len_ff + {4'b0, pk.byte_cnt};
   assign final_acc  = pk.rem_word | ({56'b0, len_new} << sh24_pkg::LEN_SHIFT);
   assign final_pend = pend_word_ff | ({56'b0, len_ff} << sh24_pkg::LEN_SHIFT);
   assign entry_xor  = pk.full ? pk.full_word : final_acc;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // round input: on accept the word enters lane d ahead of the first round
   always_comb begin
      round_in = lanes_ff;
      if (state_ff == sh24_pkg::ST_IDLE) begin
         round_in.d = lanes_ff.d ^ entry_xor;
      end
   end

   assign req_tready = (state_ff == sh24_pkg::ST_IDLE);
   assign csr_ready  = (state_ff == sh24_pkg::ST_IDLE) && !req_tvalid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = hash_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      lanes_in      = lanes_ff;
      key_low_in    = key_low_ff;
      key_high_in   = key_high_ff;
      pend_word_in  = pend_word_ff;
      pend_cnt_in   = pend_cnt_ff;
      len_in        = len_ff;
      word_in       = word_ff;
      need_final_in = need_final_ff;
      cur_final_in  = cur_final_ff;
      rnd_cnt_in    = rnd_cnt_ff;
      hash_in       = hash_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sh24_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               pend_word_in = pk.rem_word;
               pend_cnt_in  = pk.rem_cnt;
               len_in       = len_new;
               if (pk.full || req_tlast) begin
                  lanes_in      = round_out;
                  word_in       = entry_xor;
                  cur_final_in  = !pk.full;
                  need_final_in = pk.full && req_tlast;
                  rnd_cnt_in    = 2'd1;
                  state_in      = sh24_pkg::ST_MSG;
               end
            end else if (csr_valid) begin
               // key write restarts the message
               if (csr_index == sh24_pkg::CSR_KEY_LOW) begin
                  key_low_in = csr_data;
               end
               if (csr_index == sh24_pkg::CSR_KEY_HIGH) begin
                  key_high_in = csr_data;
               end
               if (csr_index == sh24_pkg::CSR_KEY_LOW || csr_index == sh24_pkg::CSR_KEY_HIGH)
               begin
                  lanes_in     = sh24_pkg::init_lanes(key_low_in, key_high_in);
                  pend_word_in = 64'b0;
                  pend_cnt_in  = 3'b0;
                  len_in       = 8'b0;
               end
            end
         end
         sh24_pkg::ST_MSG: begin
            lanes_in = round_out;
            if (rnd_cnt_ff == sh24_pkg::MSG_LAST_ROUND) begin
               lanes_in.a = round_out.a ^ word_ff;
               rnd_cnt_in = 2'd0;
               if (cur_final_ff) begin
                  lanes_in.c = round_out.c ^ sh24_pkg::FINAL_XOR;
                  state_in   = sh24_pkg::ST_FIN;
               end else if (need_final_ff) begin
                  // full word done, now the padded final word
                  lanes_in.d    = round_out.d ^ final_pend;
                  word_in       = final_pend;
                  cur_final_in  = 1'b1;
                  need_final_in = 1'b0;
               end else begin
                  state_in = sh24_pkg::ST_IDLE;
               end
            end else begin
               rnd_cnt_in = rnd_cnt_ff + 2'd1;
            end
         end
         sh24_pkg::ST_FIN: begin
            if (rnd_cnt_ff != sh24_pkg::FIN_LAST_ROUND) begin
               lanes_in   = round_out;
               rnd_cnt_in = rnd_cnt_ff + 2'd1;
            end else if (slot_free) begin
               hash_in      = round_out.a ^ round_out.b ^ round_out.c ^ round_out.d;
               rsp_valid_in = 1'b1;
               lanes_in     = sh24_pkg::init_lanes(key_low_ff, key_high_ff);
               pend_word_in = 64'b0;
               pend_cnt_in  = 3'b0;
               len_in       = 8'b0;
               cur_final_in = 1'b0;
               rnd_cnt_in   = 2'd0;
               state_in     = sh24_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sh24_pkg::ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sh24_pkg::ST_IDLE;
         lanes_ff      <= sh24_pkg::init_lanes(64'b0, 64'b0);
         key_low_ff    <= 64'b0;
         key_high_ff   <= 64'b0;
         pend_word_ff  <= 64'b0;
         pend_cnt_ff   <= 3'b0;
         len_ff        <= 8'b0;
         need_final_ff <= 1'b0;
         cur_final_ff  <= 1'b0;
         rnd_cnt_ff    <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lanes_ff      <= lanes_in;
         key_low_ff    <= key_low_in;
         key_high_ff   <= key_high_in;
         pend_word_ff  <= pend_word_in;
         pend_cnt_ff   <= pend_cnt_in;
         len_ff        <= len_in;
         need_final_ff <= need_final_in;
         cur_final_ff  <= cur_final_in;
         rnd_cnt_ff    <= rnd_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      hash_ff <= hash_in;
   end

endmodule

// File: hw/rtl/sh24_checker.sv
module sh24_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // a stalled tag holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word dropped or changed while stalled");

   // accepting a last word always starts the message rounds, so req_tready drops
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("req accepted right after a last word");

   // a new tag never appears right after an accept
   a_no_instant_tag: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("tag appeared without finalisation rounds");

   // reset leaves no tag pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind siphash24_stream_hasher_unit sh24_checker u_sh24_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/tb_siphash24_stream_hasher_unit.sv
`timescale 1ns / 1ps

module tb_siphash24_stream_hasher_unit;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLDOFF  = 300;
   localparam int RANDOM_ITEMS  = 160;

   // lane initialisation words
   localparam logic [63:0] IV_A = 64'h736f6d6570736575;
   localparam logic [63:0] IV_B = 64'h646f72616e646f6d;
   localparam logic [63:0] IV_C = 64'h6c7967656e657261;
   localparam logic [63:0] IV_D = 64'h7465646279746573;

   // register indexes with no register behind them
   localparam logic [sh24_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sh24_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  nbytes;
      logic        is_last;
   } chunk_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   // [63:0] chunk_data, [67:64] byte_count, [71:68] zero
   logic [71:0]          req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // [63:0] hash
   logic [63:0]          rsp_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [sh24_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_data   = '0;

   // hash state of the predictor
   sh24_pkg::lanes_type lanes;
   logic [63:0] k0 = '0;
   logic [63:0] k1 = '0;
   logic [63:0] gather_word;
   logic [2:0]  gather_cnt;
   logic [7:0]  msg_len;

   chunk_type   chunk_backlog[$];
   logic [63:0] pending_tags[$];
   chunk_type   offered;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic holdoff_armed = 1'b0;
   logic holdoff_taken = 1'b0;
   int   hold_left     = 0;
   int   cycle_count   = 0;
   int   tag_errors    = 0;

   siphash24_stream_hasher_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   // one sipround over all four lanes
   function automatic sh24_pkg::lanes_type mix_round(input sh24_pkg::lanes_type s);
      s.a = s.a + s.b;
      s.b = rotl(s.b, 13) ^ s.a;
      s.a = rotl(s.a, 32);
      s.c = s.c + s.d;
      s.d = rotl(s.d, 16) ^ s.c;
      s.a = s.a + s.d;
      s.d = rotl(s.d, 21) ^ s.a;
      s.c = s.c + s.b;
      s.b = rotl(s.b, 17) ^ s.c;
      s.c = rotl(s.c, 32);
      return s;
   endfunction

   function automatic void reload_lanes();
      lanes.a     = IV_A ^ k0;
      lanes.b     = IV_B ^ k1;
      lanes.c     = IV_C ^ k0;
      lanes.d     = IV_D ^ k1;
      gather_word = '0;
      gather_cnt  = '0;
      msg_len     = '0;
   endfunction

   // absorb one message word with two rounds
   function automatic void fold_word(input logic [63:0] w);
      lanes.d = lanes.d ^ w;
      lanes   = mix_round(mix_round(lanes));
      lanes.a = lanes.a ^ w;
   endfunction

   // advance the predicted hash by one chunk, queue the tag on a last chunk
   function automatic void hash_chunk(input chunk_type c);
      int          n;
      int          i;
      logic [63:0] tag;
      n = (c.nbytes > 4'd8) ? 8 : int'(c.nbytes);
      for (i = 0; i < n; i++) begin
         gather_word = gather_word | (64'(c.data[8*i +: 8]) << (8 * gather_cnt));
         if (gather_cnt == 3'd7) begin
            fold_word(gather_word);
            gather_word = '0;
            gather_cnt  = '0;
         end else begin
            gather_cnt = gather_cnt + 3'd1;
         end
      end
      msg_len = msg_len + 8'(n);
      if (c.is_last) begin
         fold_word(gather_word | {msg_len, 56'd0});
         lanes.c = lanes.c ^ 64'hff;
         for (i = 0; i < 4; i++) begin
            lanes = mix_round(lanes);
         end
         tag = lanes.a ^ lanes.b ^ lanes.c ^ lanes.d;
         pending_tags.push_back(tag);
         reload_lanes();
      end
   endfunction

   function automatic void queue_chunk(input logic [63:0] d, input logic [3:0] nb,
                                       input logic lst);
      chunk_type c;
      c.data    = d;
      c.nbytes  = nb;
      c.is_last = lst;
      chunk_backlog.push_back(c);
   endfunction

   // whole messages, mostly short, now and then longer than 256 bytes
   task automatic queue_random_messages(input int n_items);
      int         queued;
      int         n_chunks;
      int         j;
      logic [3:0] nb;
      queued = 0;
      while (queued < n_items) begin
         if ($urandom_range(99) < 6) begin
            n_chunks = $urandom_range(44, 36);
         end else begin
            n_chunks = $urandom_range(6, 1);
         end
         for (j = 0; j < n_chunks; j++) begin
            if (n_chunks > 32) begin
               nb = ($urandom_range(9) == 0) ? 4'($urandom_range(7)) : 4'd8;
            end else if ($urandom_range(9) == 0) begin
               nb = 4'($urandom_range(15, 9));
            end else begin
               nb = 4'($urandom_range(8));
            end
            queue_chunk({$urandom, $urandom}, nb, j == n_chunks - 1);
         end
         queued += n_chunks;
      end
   endtask

   // register write, held until the block takes it while idle
   task automatic write_csr(input logic [sh24_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == sh24_pkg::CSR_KEY_LOW) begin
         k0 = val;
         reload_lanes();
      end else if (idx == sh24_pkg::CSR_KEY_HIGH) begin
         k1 = val;
         reload_lanes();
      end
   endtask

   // all words sent, all tags back, then let unfinished rounds run out
   task automatic wait_idle();
      @(negedge clock);
      while (chunk_backlog.size() != 0 || req_tvalid || pending_tags.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sender: offers backlog words with random gaps
   always @(posedge clock) begin : drive_chunks
      chunk_type next_chunk;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            hash_chunk(offered);
         end
         if (!req_tvalid || req_tready) begin
            if (chunk_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_chunk = chunk_backlog.pop_front();
               offered    <= next_chunk;
               req_tdata  <= {4'd0, next_chunk.nbytes, next_chunk.data};
               req_tlast  <= next_chunk.is_last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_armed && !holdoff_taken) begin
         holdoff_taken <= 1'b1;
         hold_left     <= LONG_HOLDOFF;
         rsp_tready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // compare each tag word with the oldest prediction
   always @(posedge clock) begin : check_tags
      logic [63:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tags.size() == 0) begin
            $display("%0t: unexpected tag, expected none, actual %h", $time, rsp_tdata);
            tag_errors++;
         end else begin
            want = pending_tags.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: tag mismatch, expected %h, actual %h", $time, want, rsp_tdata);
               tag_errors++;
            end
         end
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("siphash24_stream_hasher_unit test failed");
         $finish;
      end
   end

   initial begin
      send_idle_pct = 38;
      rsp_stall_pct = 88;
      reload_lanes();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // keys as left by reset: empty message and one full word
      queue_chunk(64'd0, 4'd0, 1'b1);
      queue_chunk('1, 4'd8, 1'b1);
      wait_idle();

      // byte-sequence key, field extremes and word boundaries across chunks
      write_csr(sh24_pkg::CSR_KEY_LOW, 64'h0706050403020100);
      write_csr(sh24_pkg::CSR_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
      queue_chunk(64'd0, 4'd0, 1'b1);
      queue_chunk(64'h0706050403020100, 4'd8, 1'b1);
      queue_chunk('1, 4'd15, 1'b1);
      queue_chunk(64'hffffffffff020100, 4'd3, 1'b0);
      queue_chunk(64'hdeadbeef07060504, 4'd5, 1'b0);
      queue_chunk('1, 4'd0, 1'b0);
      queue_chunk({$urandom, $urandom}, 4'd9, 1'b1);
      queue_chunk(64'hff0e0d0c0b0a0908, 4'd7, 1'b0);
      queue_chunk(64'h8016151413121110, 4'd7, 1'b0);
      queue_chunk(64'h5555555555551a19, 4'd2, 1'b1);
      queue_chunk(64'd0, 4'd12, 1'b1);
      queue_chunk('1, 4'd1, 1'b1);
      wait_idle();

      // write to a spare index in mid-message leaves the message alone
      queue_chunk({$urandom, $urandom}, 4'd8, 1'b0);
      queue_chunk({$urandom, $urandom}, 4'd4, 1'b0);
      wait_idle();
      write_csr(CSR_SPARE_2, {$urandom, $urandom});
      queue_chunk({$urandom, $urandom}, 4'd4, 1'b1);
      wait_idle();

      // key write in mid-message restarts it
      queue_chunk({$urandom, $urandom}, 4'd6, 1'b0);
      queue_chunk({$urandom, $urandom}, 4'd8, 1'b0);
      wait_idle();
      write_csr(sh24_pkg::CSR_KEY_LOW, '1);
      write_csr(sh24_pkg::CSR_KEY_HIGH, '1);
      queue_chunk({$urandom, $urandom}, 4'd8, 1'b1);
      queue_chunk(64'd0, 4'd0, 1'b1);
      wait_idle();

      // random messages, sender mostly busy, receiver mostly stalled
      queue_random_messages(RANDOM_ITEMS);
      wait_idle();

      // random key, sender mostly idle, receiver mostly ready
      write_csr(CSR_SPARE_3, {$urandom, $urandom});
      write_csr(sh24_pkg::CSR_KEY_LOW, {$urandom, $urandom});
      write_csr(sh24_pkg::CSR_KEY_HIGH, {$urandom, $urandom});
      send_idle_pct = 88;
      rsp_stall_pct = 38;
      queue_random_messages(RANDOM_ITEMS);
      wait_idle();

      // full rate with a long receiver hold-off to back the block up
      write_csr(sh24_pkg::CSR_KEY_HIGH, {$urandom, $urandom});
      write_csr(sh24_pkg::CSR_KEY_LOW, {$urandom, $urandom});
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_armed <= 1'b1;
      queue_random_messages(RANDOM_ITEMS);
      wait_idle();

      if (tag_errors == 0) begin
         $display("siphash24_stream_hasher_unit test passed");
      end else begin
         $display("siphash24_stream_hasher_unit test failed");
      end
      $finish;
   end

endmodule

// File: siphash24_stream_hasher_unit.f
hw/rtl/sh24_pkg.sv
hw/rtl/sh24_round.sv
hw/rtl/sh24_pack.sv
hw/rtl/siphash24_stream_hasher_unit.sv
hw/rtl/sh24_checker.sv
sim/tb_siphash24_stream_hasher_unit.sv
